// ===== design/msrs_pkg.sv =====
// ----------------------------------------------------------------------------
// msrs_pkg
// Shared types and constants of the multiset random sampler.
// ----------------------------------------------------------------------------
package msrs_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int RAND_W   = 31;
	localparam int BIT_W    = $clog2(RAND_W + 1);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	localparam logic signed [DATA_W-1:0] NO_SAMPLE = -32'sd1;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [DATA_W-1:0] value;
		logic [RAND_W-1:0]        rand_word;
	} req_t;

	typedef struct packed {
		logic                     flag;
		logic signed [DATA_W-1:0] sample_value;
		logic                     empty_res;
		logic                     full_res;
	} rsp_t;

	typedef enum logic [1:0] {
		RD_SRCH,
		RD_LAST,
		RD_SMP
	} rd_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEARCH,
		ST_INS_WR,
		ST_RD_LAST,
		ST_REM_WR,
		ST_DIVIDE,
		ST_RD_SMP,
		ST_SMP_CAP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    srch_start;
		logic    srch_en;
		rd_src_t rd_src;
		logic    ins_wr;
		logic    rem_wr;
		logic    set_full;
		logic    set_empty;
		logic    div_start;
		logic    div_en;
		logic    smp_cap;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       full;
		logic       empty;
		logic       srch_done;
		logic       found;
		logic       div_done;
		logic       out_free;
	} sts_t;

endpackage

// ===== design/msrs_ram.sv =====
// ----------------------------------------------------------------------------
// msrs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module msrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/msrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// msrs_ctrl
// Request sequencer: decode, store search, update, modulo and result hand-off.
// ----------------------------------------------------------------------------
module msrs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  msrs_pkg::sts_t  sts,
	output msrs_pkg::cmd_t  cmd
);

	msrs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.rd_src = msrs_pkg::RD_SRCH;
		req_ready = 1'b0;
		unique case (state_q)
			msrs_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = msrs_pkg::ST_DECODE;
				end
			end
			msrs_pkg::ST_DECODE: begin
				unique case (sts.req_type)
					msrs_pkg::REQ_INSERT: begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
							state_d      = msrs_pkg::ST_FINISH;
						end else begin
							cmd.srch_start = 1'b1;
							state_d        = msrs_pkg::ST_SEARCH;
						end
					end
					msrs_pkg::REQ_REMOVE: begin
						cmd.srch_start = 1'b1;
						state_d        = msrs_pkg::ST_SEARCH;
					end
					msrs_pkg::REQ_SAMPLE: begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
							state_d       = msrs_pkg::ST_FINISH;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = msrs_pkg::ST_DIVIDE;
						end
					end
					default: begin
						state_d = msrs_pkg::ST_FINISH;
					end
				endcase
			end
			msrs_pkg::ST_SEARCH: begin
				cmd.srch_en = 1'b1;
				if (sts.srch_done) begin
					if (sts.req_type == msrs_pkg::REQ_INSERT) begin
						state_d = msrs_pkg::ST_INS_WR;
					end else begin
						state_d = msrs_pkg::ST_RD_LAST;
					end
				end
			end
			msrs_pkg::ST_INS_WR: begin
				cmd.ins_wr = 1'b1;
				state_d    = msrs_pkg::ST_FINISH;
			end
			msrs_pkg::ST_RD_LAST: begin
				if (sts.found) begin
					cmd.rd_src = msrs_pkg::RD_LAST;
					state_d    = msrs_pkg::ST_REM_WR;
				end else begin
					state_d = msrs_pkg::ST_FINISH;
				end
			end
			msrs_pkg::ST_REM_WR: begin
				cmd.rem_wr = 1'b1;
				state_d    = msrs_pkg::ST_FINISH;
			end
			msrs_pkg::ST_DIVIDE: begin
				if (sts.div_done) begin
					state_d = msrs_pkg::ST_RD_SMP;
				end else begin
					cmd.div_en = 1'b1;
				end
			end
			msrs_pkg::ST_RD_SMP: begin
				cmd.rd_src = msrs_pkg::RD_SMP;
				state_d    = msrs_pkg::ST_SMP_CAP;
			end
			msrs_pkg::ST_SMP_CAP: begin
				cmd.smp_cap = 1'b1;
				state_d     = msrs_pkg::ST_FINISH;
			end
			msrs_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = msrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = msrs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/msrs_dp.sv =====
// ----------------------------------------------------------------------------
// msrs_dp
// Element store, count, descending search pipeline, restoring modulo unit
// and the result register.
// ----------------------------------------------------------------------------
module msrs_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  msrs_pkg::req_t  req,
	input  msrs_pkg::cmd_t  cmd,
	output msrs_pkg::sts_t  sts,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output msrs_pkg::rsp_t  rsp
);

	localparam int AW = msrs_pkg::ADDR_W;
	localparam int CW = msrs_pkg::CNT_W;
	localparam int RW = msrs_pkg::RAND_W;

	msrs_pkg::req_t             req_q;
	msrs_pkg::rsp_t             res_q;
	msrs_pkg::rsp_t             rsp_q;
	logic                       rsp_valid_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              idx_q;
	logic                       pend_s1;
	logic [AW-1:0]              addr_s1;
	logic                       found_q;
	logic [AW-1:0]              pos_q;
	logic [RW-1:0]              div_q;
	logic [CW-1:0]              rem_q;
	logic [msrs_pkg::BIT_W-1:0] bit_q;

	logic [CW-1:0]               idx_m1;
	logic [CW-1:0]               cnt_m1;
	logic [AW-1:0]               raddr;
	logic [msrs_pkg::DATA_W-1:0] rdata;
	logic                        we;
	logic [AW-1:0]               waddr;
	logic [msrs_pkg::DATA_W-1:0] wdata;
	logic                        hit;
	logic                        issue;
	logic [CW:0]                 rem_sh;
	logic [CW:0]                 rem_sub;
	logic                        rem_ge;
	logic [CW-1:0]               rem_nxt;

	assign idx_m1 = idx_q - 1'b1;
	assign cnt_m1 = count_q - 1'b1;

	always_comb begin
		case (cmd.rd_src)
			msrs_pkg::RD_SRCH: raddr = idx_m1[AW-1:0];
			msrs_pkg::RD_LAST: raddr = cnt_m1[AW-1:0];
			msrs_pkg::RD_SMP:  raddr = rem_q[AW-1:0];
			default:           raddr = '0;
		endcase
	end

	assign we    = cmd.ins_wr | cmd.rem_wr;
	assign waddr = cmd.ins_wr ? count_q[AW-1:0] : pos_q;
	assign wdata = cmd.ins_wr ? $unsigned(req_q.value) : rdata;

	msrs_ram #(
		.WIDTH(msrs_pkg::DATA_W),
		.DEPTH(msrs_pkg::CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// search walks from the top entry down; stops at the first (highest) match
	assign hit   = pend_s1 && (rdata == $unsigned(req_q.value));
	assign issue = cmd.srch_en && (idx_q != '0) && !hit;

	// restoring modulo step
	assign rem_sh  = {rem_q, div_q[RW-1]};
	assign rem_ge  = rem_sh >= {1'b0, count_q};
	assign rem_sub = rem_sh - {1'b0, count_q};
	assign rem_nxt = rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			bit_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_wr) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.rem_wr) begin
				count_q <= cnt_m1;
			end
			if (cmd.srch_start) begin
				idx_q   <= count_q;
				pend_s1 <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.srch_en) begin
				pend_s1 <= issue;
				if (issue) begin
					idx_q <= idx_m1;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.div_start) begin
				bit_q <= msrs_pkg::BIT_W'(RW);
			end else if (cmd.div_en) begin
				bit_q <= bit_q - 1'b1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q              <= req;
			res_q.flag         <= 1'b0;
			res_q.sample_value <= msrs_pkg::NO_SAMPLE;
			res_q.empty_res    <= 1'b0;
			res_q.full_res     <= 1'b0;
		end
		if (cmd.set_full) begin
			res_q.full_res <= 1'b1;
		end
		if (cmd.set_empty) begin
			res_q.empty_res <= 1'b1;
		end
		if (cmd.ins_wr) begin
			res_q.flag <= !found_q;
		end
		if (cmd.rem_wr) begin
			res_q.flag <= 1'b1;
		end
		if (cmd.smp_cap) begin
			res_q.sample_value <= $signed(rdata);
		end
		if (cmd.srch_en) begin
			addr_s1 <= idx_m1[AW-1:0];
			if (hit) begin
				pos_q <= addr_s1;
			end
		end
		if (cmd.div_start) begin
			div_q <= req_q.rand_word;
			rem_q <= '0;
		end else if (cmd.div_en) begin
			div_q <= {div_q[RW-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	assign sts.req_type  = req_q.req_type;
	assign sts.full      = count_q == CW'(msrs_pkg::CAPACITY);
	assign sts.empty     = count_q == '0;
	assign sts.srch_done = hit || ((idx_q == '0) && !pend_s1);
	assign sts.found     = found_q;
	assign sts.div_done  = bit_q == '0;
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/multiset_random_sampler.sv =====
// ----------------------------------------------------------------------------
// multiset_random_sampler
// Bounded multiset with insert, remove-one and uniform sample by index.
// ----------------------------------------------------------------------------
//  channel | signals                  | payload
//  --------+--------------------------+--------------------------------------
//  request | req_valid / req_ready    | req : req_type, value, rand_word
//  result  | rsp_valid / rsp_ready    | rsp : flag, sample_value, empty_res,
//          |                          |       full_res
//
//  Insert and remove search the store one entry per cycle through its single
//  read port. Sample runs the one-bit-per-cycle modulo unit; refused insert,
//  empty sample and unused codes go straight from decode to the result
//  hand-off. A new request is taken in the cycle after the result is loaded.
//  Reset clears the count; store contents need no clearing.
//  A held result stalls the next request only at its final hand-off.
// ----------------------------------------------------------------------------
module multiset_random_sampler (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  msrs_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output msrs_pkg::rsp_t  rsp
);

	msrs_pkg::cmd_t cmd;
	msrs_pkg::sts_t sts;

	msrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msrs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

// ===== design/msrs_checker.sv =====
// ----------------------------------------------------------------------------
// msrs_checker
// Port-level checks of the multiset random sampler.
// ----------------------------------------------------------------------------
module msrs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input msrs_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input msrs_pkg::rsp_t rsp
);

	// one request in flight at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while previous one is in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.full_res) |->
		(!rsp.flag && !rsp.empty_res && rsp.sample_value == msrs_pkg::NO_SAMPLE))
		else $error("refused insert reports other fields");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.empty_res) |->
		(!rsp.flag && rsp.sample_value == msrs_pkg::NO_SAMPLE))
		else $error("empty sample reports other fields");

endmodule

bind multiset_random_sampler msrs_checker u_msrs_checker (.*);

// ===== tb/sv/multiset_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_result_checker
// Watches the request and result channels of the multiset sampler, keeps a
// shadow copy of the element store, predicts one result per request and
// compares every returned result field by field in order.
// ----------------------------------------------------------------------------
module multiset_result_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  msrs_pkg::req_t  req,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  msrs_pkg::rsp_t  rsp,
	output int              fail_count,
	output int              outstanding,
	output int              stored_count
);

	logic signed [msrs_pkg::DATA_W-1:0] shadow_elems [msrs_pkg::CAPACITY];
	int unsigned                        shadow_count;
	msrs_pkg::rsp_t                     predicted_rsp_q [$];
	msrs_pkg::rsp_t                     want;
	int                                 misses;

	// highest occupied position holding v, -1 when absent
	function automatic int highest_match(logic signed [msrs_pkg::DATA_W-1:0] v);
		for (int i = int'(shadow_count) - 1; i >= 0; i--) begin
			if (shadow_elems[i] == v)
				return i;
		end
		return -1;
	endfunction

	function automatic msrs_pkg::rsp_t apply_request(msrs_pkg::req_t r);
		msrs_pkg::rsp_t res;
		int             hit;
		res.flag         = 1'b0;
		res.sample_value = msrs_pkg::NO_SAMPLE;
		res.empty_res    = 1'b0;
		res.full_res     = 1'b0;
		case (r.req_type)
			msrs_pkg::REQ_INSERT: begin
				if (shadow_count >= msrs_pkg::CAPACITY) begin
					res.full_res = 1'b1;
				end else begin
					res.flag = (highest_match(r.value) < 0);
					shadow_elems[shadow_count] = r.value;
					shadow_count++;
				end
			end
			msrs_pkg::REQ_REMOVE: begin
				hit = highest_match(r.value);
				if (hit >= 0) begin
					shadow_elems[hit] = shadow_elems[shadow_count - 1];
					shadow_count--;
					res.flag = 1'b1;
				end
			end
			msrs_pkg::REQ_SAMPLE: begin
				if (shadow_count == 0)
					res.empty_res = 1'b1;
				else
					res.sample_value = shadow_elems[r.rand_word % shadow_count];
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			predicted_rsp_q.delete();
			fail_count   <= 0;
			outstanding  <= 0;
			stored_count <= 0;
		end else begin
			misses = 0;
			if (rsp_valid && rsp_ready) begin
				if (predicted_rsp_q.size() == 0) begin
					$display("%0t: unexpected result flag=%0b sample_value=%0d",
						$time, rsp.flag, rsp.sample_value);
					$display("%0t: unexpected result empty=%0b full=%0b",
						$time, rsp.empty_res, rsp.full_res);
					misses++;
				end else begin
					want = predicted_rsp_q.pop_front();
					if (rsp.flag !== want.flag) begin
						$display("%0t: flag expected %0b, got %0b", $time, want.flag, rsp.flag);
						misses++;
					end
					if (rsp.sample_value !== want.sample_value) begin
						$display("%0t: sample_value expected %0d, got %0d",
							$time, want.sample_value, rsp.sample_value);
						misses++;
					end
					if (rsp.empty_res !== want.empty_res) begin
						$display("%0t: empty_res expected %0b, got %0b",
							$time, want.empty_res, rsp.empty_res);
						misses++;
					end
					if (rsp.full_res !== want.full_res) begin
						$display("%0t: full_res expected %0b, got %0b",
							$time, want.full_res, rsp.full_res);
						misses++;
					end
				end
			end
			if (req_valid && req_ready)
				predicted_rsp_q = {predicted_rsp_q, apply_request(req)};
			fail_count   <= fail_count + misses;
			outstanding  <= outstanding + int'(req_valid && req_ready)
				- int'(rsp_valid && rsp_ready);
			stored_count <= int'(shadow_count);
		end
	end

endmodule

// ===== tb/sv/multiset_random_sampler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_random_sampler_tb
// Drives the multiset sampler with directed corner requests, random mixes of
// insert, remove, sample and unused codes under four idle and stall patterns,
// and a closing mix; results are checked by the companion result checker.
// ----------------------------------------------------------------------------
module multiset_random_sampler_tb;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic signed [msrs_pkg::DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
	localparam logic signed [msrs_pkg::DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
	localparam int CYCLE_LIMIT      = 6_000_000;
	localparam int RANDOM_PER_PHASE = 132;
	localparam int SETTLE_CYCLES    = 1100;
	localparam int POOL_SIZE        = 12;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	msrs_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	msrs_pkg::rsp_t rsp;

	int fail_count;
	int outstanding;
	int stored_count;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int cycle_count = 0;

	logic signed [msrs_pkg::DATA_W-1:0] value_pool [POOL_SIZE];

	multiset_random_sampler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	multiset_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.stored_count (stored_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_request(input logic [1:0] kind,
		input logic signed [msrs_pkg::DATA_W-1:0] v,
		input logic [msrs_pkg::RAND_W-1:0] rw);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid <= 1'b1;
		req       <= '{req_type: kind, value: v, rand_word: rw};
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic wait_results_done();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic signed [msrs_pkg::DATA_W-1:0] pick_value(int pool_pct);
		if ($urandom_range(99) < pool_pct)
			return value_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic logic [msrs_pkg::RAND_W-1:0] pick_rand_word();
		logic [31:0] w;
		case ($urandom_range(9))
			0: w = '0;
			1: w = '1;
			2: w = $urandom_range(63);
			default: w = $urandom;
		endcase
		return w[msrs_pkg::RAND_W-1:0];
	endfunction

	// keeps the store small so searches stay short
	task automatic send_random();
		int roll;
		int ins_w;
		int rem_w;
		roll = $urandom_range(99);
		if (stored_count < 8) begin
			ins_w = 55;
			rem_w = 15;
		end else if (stored_count > 40) begin
			ins_w = 20;
			rem_w = 50;
		end else begin
			ins_w = 35;
			rem_w = 30;
		end
		if (roll < ins_w)
			send_request(msrs_pkg::REQ_INSERT, pick_value(80), pick_rand_word());
		else if (roll < ins_w + rem_w)
			send_request(msrs_pkg::REQ_REMOVE, pick_value(85), pick_rand_word());
		else if (roll < 95)
			send_request(msrs_pkg::REQ_SAMPLE, $urandom, pick_rand_word());
		else
			send_request(REQ_UNUSED, pick_value(50), pick_rand_word());
	endtask

	initial begin
		value_pool[0] = MIN_VAL;
		value_pool[1] = MAX_VAL;
		value_pool[2] = '0;
		value_pool[3] = '1;
		value_pool[4] = 32'sd1;
		value_pool[5] = 32'sh5555_5555;
		value_pool[6] = 32'shAAAA_AAAA;
		for (int i = 7; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store
		send_request(msrs_pkg::REQ_SAMPLE, 32'sd5, '0);
		send_request(msrs_pkg::REQ_SAMPLE, '0, '1);
		send_request(msrs_pkg::REQ_REMOVE, 32'sd7, '0);
		send_request(REQ_UNUSED, '1, '1);
		// extremes and a duplicate
		send_request(msrs_pkg::REQ_INSERT, MIN_VAL, '0);
		send_request(msrs_pkg::REQ_INSERT, MAX_VAL, '1);
		send_request(msrs_pkg::REQ_INSERT, '0, '0);
		send_request(msrs_pkg::REQ_INSERT, '1, '0);
		send_request(msrs_pkg::REQ_INSERT, MIN_VAL, '0);
		send_request(msrs_pkg::REQ_INSERT, 32'shAAAA_AAAA, '0);
		send_request(msrs_pkg::REQ_INSERT, 32'sh5555_5555, '1);
		send_request(msrs_pkg::REQ_SAMPLE, '1, '0);
		send_request(msrs_pkg::REQ_SAMPLE, MIN_VAL, '1);
		send_request(msrs_pkg::REQ_SAMPLE, '0, 31'd9);
		// highest copy, absent value, last element
		send_request(msrs_pkg::REQ_REMOVE, MIN_VAL, '0);
		send_request(msrs_pkg::REQ_REMOVE, 32'sd123456, '0);
		send_request(msrs_pkg::REQ_REMOVE, 32'shAAAA_AAAA, '0);
		send_request(REQ_UNUSED, MAX_VAL, '0);
		send_request(msrs_pkg::REQ_SAMPLE, '0, '1);
		send_request(msrs_pkg::REQ_REMOVE, MIN_VAL, '1);
		send_request(msrs_pkg::REQ_INSERT, MIN_VAL, '0);
		wait_results_done();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 57; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 57; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			repeat (RANDOM_PER_PHASE) send_random();
			wait_results_done();
		end

		send_request(msrs_pkg::REQ_INSERT, MAX_VAL, '0);
		send_request(msrs_pkg::REQ_SAMPLE, '0, '0);
		send_request(msrs_pkg::REQ_SAMPLE, '0, '1);
		send_request(msrs_pkg::REQ_SAMPLE, '0, pick_rand_word());
		send_request(msrs_pkg::REQ_REMOVE, 32'sh1357_9BDF, '0);
		send_request(msrs_pkg::REQ_REMOVE, value_pool[0], '0);
		send_request(msrs_pkg::REQ_INSERT, '1, '0);
		send_request(msrs_pkg::REQ_INSERT, '0, '0);
		send_request(REQ_UNUSED, '0, '1);
		send_request(msrs_pkg::REQ_SAMPLE, '1, '1);
		wait_results_done();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
